### design/oaid_pkg.sv
package oaid_pkg;

    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_SIZE    = 2'd0,
        OP_DISPLAY = 2'd1,
        OP_INSERT  = 2'd2,
        OP_DELETE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic                      pos_zero;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
        logic                      shift_mode;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic [COUNT_W-1:0]        count;
        status_t                   status;
        logic                      last;
    } res_t;

endpackage

### design/oaid_fifo.sv
module oaid_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/oaid_front.sv
module oaid_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          opcode,
    input  logic [oaid_pkg::POS_W-1:0]          position,
    input  logic signed [oaid_pkg::DATA_W-1:0]  value,
    input  logic                                delete_mode,
    output logic                                cmd_valid,
    output oaid_pkg::cmd_t                      cmd,
    input  logic                                cmd_pop
);

    localparam int CMD_W = $bits(oaid_pkg::cmd_t);

    oaid_pkg::cmd_t   cmd_in;
    logic [CMD_W-1:0] cmd_bits;
    logic             cmd_empty;

    // classify the item; value is only kept for inserts
    always_comb
    begin
        cmd_in.op         = oaid_pkg::op_t'(opcode);
        cmd_in.pos_zero   = (position == '0);
        cmd_in.pos        = position;
        cmd_in.shift_mode = delete_mode;
        case (cmd_in.op)
            oaid_pkg::OP_INSERT: cmd_in.value = value;
            default:             cmd_in.value = '0;
        endcase
    end

    oaid_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd       = cmd_bits;
    assign cmd_valid = !cmd_empty;

endmodule

### design/oaid_back.sv
module oaid_back #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  oaid_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_push,
    output oaid_pkg::res_t res,
    input  logic           res_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = ((CNT_W > oaid_pkg::POS_W) ? CNT_W : oaid_pkg::POS_W) + 1;

    logic [oaid_pkg::DATA_W-1:0] entries_reg  [CAPACITY];
    logic [oaid_pkg::DATA_W-1:0] entries_next [CAPACITY];
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [IDX_W-1:0]            ptr_reg;
    logic [IDX_W-1:0]            ptr_next;
    oaid_pkg::state_t            state_reg;
    oaid_pkg::state_t            state_next;

    logic                        go;
    logic [CMP_W-1:0]            pos_x;
    logic [CMP_W-1:0]            cnt_x;
    logic [CMP_W-1:0]            hole_x;
    logic [CMP_W-1:0]            tail_x;
    logic [CNT_W-1:0]            tail;
    logic [IDX_W-1:0]            rd_addr;
    logic [oaid_pkg::DATA_W-1:0] rd_data;
    logic                        ins_ok;
    logic                        del_ok;
    logic                        disp_last;

    assign go       = cmd_valid && !res_full;
    assign pos_x    = CMP_W'(cmd.pos);
    assign cnt_x    = CMP_W'(count_reg);
    assign hole_x   = pos_x - CMP_W'(1);
    assign tail     = count_reg - CNT_W'(1);
    assign tail_x   = CMP_W'(tail);
    assign ins_ok   = (pos_x <= cnt_x) && (cnt_x != CMP_W'(CAPACITY));
    assign del_ok   = !cmd.pos_zero && (pos_x <= cnt_x);

    // single read port: display pointer while streaming, else the last entry
    assign rd_addr   = (state_reg == oaid_pkg::S_DISP) ? ptr_reg : IDX_W'(tail);
    assign rd_data   = entries_reg[rd_addr];
    assign disp_last = (CNT_W'(ptr_reg) == tail);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oaid_pkg::S_IDLE:
            begin
                if (go && cmd.op == oaid_pkg::OP_DISPLAY && count_reg != '0)
                begin
                    state_next = oaid_pkg::S_DISP;
                end
            end
            oaid_pkg::S_DISP:
            begin
                if (!res_full && disp_last)
                begin
                    state_next = oaid_pkg::S_IDLE;
                end
            end
            default: state_next = oaid_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res.data     = '0;
        res.status   = oaid_pkg::ST_OK;
        res.last     = 1'b1;
        case (state_reg)
            oaid_pkg::S_IDLE:
            begin
                if (go)
                begin
                    cmd_pop  = 1'b1;
                    res_push = 1'b1;
                    case (cmd.op)
                        oaid_pkg::OP_DISPLAY:
                        begin
                            ptr_next = '0;
                            if (count_reg == '0)
                            begin
                                res.status = oaid_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // no result yet; the entries stream out in S_DISP
                                res_push = 1'b0;
                            end
                        end
                        oaid_pkg::OP_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                for (int i = 1; i < CAPACITY; i++)
                                begin
                                    if (CMP_W'(i) > pos_x)
                                    begin
                                        entries_next[i] = entries_reg[i-1];
                                    end
                                end
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CMP_W'(i) == pos_x)
                                    begin
                                        entries_next[i] = cmd.value;
                                    end
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res.status = oaid_pkg::ST_INVALID;
                            end
                        end
                        oaid_pkg::OP_DELETE:
                        begin
                            if (del_ok)
                            begin
                                for (int i = 0; i < CAPACITY - 1; i++)
                                begin
                                    if (cmd.shift_mode && CMP_W'(i) >= hole_x
                                        && CMP_W'(i) < tail_x)
                                    begin
                                        entries_next[i] = entries_reg[i+1];
                                    end
                                end
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (!cmd.shift_mode && CMP_W'(i) == hole_x)
                                    begin
                                        entries_next[i] = rd_data;
                                    end
                                    // vacated slot drops to zero
                                    if (CMP_W'(i) == tail_x)
                                    begin
                                        entries_next[i] = '0;
                                    end
                                end
                                count_next = tail;
                            end
                            else
                            begin
                                res.status = oaid_pkg::ST_INVALID;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            oaid_pkg::S_DISP:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    res.data = rd_data;
                    res.last = disp_last;
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
        res.count = oaid_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oaid_pkg::S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            entries_reg <= entries_next;
        end
    end

endmodule

### design/ordered_array_insert_delete_core.sv
// Ordered array of up to CAPACITY signed 32-bit entries with insert, delete,
// display and size query.
// Input channel: drive opcode, position, value and delete_mode with push; the
// item is taken on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on data, count,
// status and last; pop on a clock edge with empty low takes it.
// A two-entry command queue sits in front of the execution unit and a
// two-entry result queue behind it, so either side may stall freely.
// Size query, insert and delete each give one result; an insert or a
// shifting delete moves all affected cells in parallel. Display of n
// entries first starts the stream, then gives one result per cycle while
// the result queue is not full, read through the single array read port;
// last marks the final one. An item taken waits in the command queue, is
// executed from there and its result is registered in the result queue.
// Reset empties both queues, clears the array to zero and the count to zero.
// When the receiver stops popping, the result queue fills, the execution
// unit holds, then the command queue fills and full rises.
module ordered_array_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           opcode,
    input  logic [oaid_pkg::POS_W-1:0]           position,
    input  logic signed [oaid_pkg::DATA_W-1:0]   value,
    input  logic                                 delete_mode,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [oaid_pkg::DATA_W-1:0]   data,
    output logic [oaid_pkg::COUNT_W-1:0]         count,
    output logic [oaid_pkg::STATUS_W-1:0]        status,
    output logic                                 last
);

    localparam int RES_W = $bits(oaid_pkg::res_t);

    oaid_pkg::cmd_t   cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    oaid_pkg::res_t   res_in;
    oaid_pkg::res_t   res_out;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_bits;

    oaid_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .delete_mode (delete_mode),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    oaid_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    oaid_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_out = res_bits;
    assign data    = res_out.data;
    assign count   = res_out.count;
    assign status  = res_out.status;
    assign last    = res_out.last;

endmodule

### sim/ordered_array_insert_delete_core_tb.sv
`timescale 1ns / 1ps

module ordered_array_insert_delete_core_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 58;   // per idling phase
    localparam int SETTLE_CYCLES = 20;
    localparam int POS_W        = oaid_pkg::POS_W;
    localparam int DATA_W       = oaid_pkg::DATA_W;
    localparam int COUNT_W      = oaid_pkg::COUNT_W;
    localparam int STATUS_W     = oaid_pkg::STATUS_W;

    typedef struct {
        oaid_pkg::op_t            op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        logic                     mode;
        bit                       typed;
        oaid_pkg::status_t        want_status;
        logic [COUNT_W-1:0]       want_count;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [1:0]                 opcode = '0;
    logic [POS_W-1:0]           position = '0;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       delete_mode = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]         count;
    logic [STATUS_W-1:0]        status;
    logic                       last;

    // shadow copy of the array contents
    logic signed [DATA_W-1:0]   mirror_entries [CAPACITY];
    int                         mirror_fill;
    oaid_pkg::res_t             op_results [CAPACITY];
    int                         op_result_n;
    oaid_pkg::res_t             awaited_results [$];

    int                         errors = 0;
    int                         feed_idle_pct = 22;
    int                         drain_idle_pct = 75;
    bit                         growing = 1'b1;
    stim_row_t                  directed_table [$];

    ordered_array_insert_delete_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .delete_mode (delete_mode),
        .empty       (empty),
        .pop         (pop),
        .data        (data),
        .count       (count),
        .status      (status),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic oaid_pkg::res_t make_result(input logic signed [DATA_W-1:0] d,
                                                   input oaid_pkg::status_t st,
                                                   input logic lst);
        oaid_pkg::res_t r;
        r.data   = d;
        r.count  = COUNT_W'(mirror_fill);
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    // Apply one operation to the shadow array and collect the results it gives.
    task automatic apply_array_op(input oaid_pkg::op_t op, input logic [POS_W-1:0] pos,
                                  input logic signed [DATA_W-1:0] val, input logic mode);
        int                p;
        int                hole;
        int                tail;
        oaid_pkg::status_t st;
        p = int'(pos);
        st = oaid_pkg::ST_OK;
        op_result_n = 0;
        case (op)
            oaid_pkg::OP_DISPLAY:
            begin
                if (mirror_fill == 0)
                begin
                    op_results[0] = make_result('0, oaid_pkg::ST_EMPTY, 1'b1);
                    op_result_n = 1;
                end
                else
                begin
                    for (int i = 0; i < mirror_fill; i++)
                        op_results[i] = make_result(mirror_entries[i], oaid_pkg::ST_OK,
                                                    i + 1 == mirror_fill);
                    op_result_n = mirror_fill;
                end
            end
            oaid_pkg::OP_INSERT:
            begin
                if (p > mirror_fill || mirror_fill >= CAPACITY)
                    st = oaid_pkg::ST_INVALID;
                else
                begin
                    for (int i = mirror_fill; i > p; i--)
                        mirror_entries[i] = mirror_entries[i - 1];
                    mirror_entries[p] = val;
                    mirror_fill++;
                end
            end
            oaid_pkg::OP_DELETE:
            begin
                if (p == 0 || p > mirror_fill)
                    st = oaid_pkg::ST_INVALID;
                else
                begin
                    hole = p - 1;
                    tail = mirror_fill - 1;
                    if (hole != tail)
                    begin
                        if (mode)
                        begin
                            for (int i = hole; i < tail; i++)
                                mirror_entries[i] = mirror_entries[i + 1];
                        end
                        else
                            mirror_entries[hole] = mirror_entries[tail];
                    end
                    mirror_entries[tail] = '0;
                    mirror_fill--;
                end
            end
            default: ;
        endcase
        if (op != oaid_pkg::OP_DISPLAY)
        begin
            op_results[0] = make_result('0, st, 1'b1);
            op_result_n = 1;
        end
    endtask

    // Hold the item on the inputs until the block takes it.
    task automatic drive_item(input oaid_pkg::op_t op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val, input logic mode);
        push        <= 1'b1;
        opcode      <= op;
        position    <= pos;
        value       <= val;
        delete_mode <= mode;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic feed_gap();
        while ($urandom_range(0, 99) < feed_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_random_item(output oaid_pkg::op_t op, output logic [POS_W-1:0] pos,
                                    output logic signed [DATA_W-1:0] val, output logic mode);
        int r;
        if (mirror_fill == CAPACITY && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        if (mirror_fill == 0)
            growing = 1'b1;
        r = $urandom_range(0, 99);
        if (r >= 90)
        begin
            // noise: anything the fields allow
            op  = oaid_pkg::op_t'($urandom_range(0, 3));
            pos = POS_W'($urandom_range(0, 31));
        end
        else if (r < (growing ? 55 : 15))
        begin
            op  = oaid_pkg::OP_INSERT;
            pos = POS_W'($urandom_range(0, mirror_fill));
        end
        else if (r < (growing ? 70 : 60))
        begin
            op  = oaid_pkg::OP_DELETE;
            pos = (mirror_fill == 0) ? POS_W'(1) : POS_W'($urandom_range(1, mirror_fill));
        end
        else if (r < 78)
        begin
            op  = oaid_pkg::OP_DISPLAY;
            pos = POS_W'($urandom_range(0, 31));
        end
        else
        begin
            op  = oaid_pkg::OP_SIZE;
            pos = POS_W'($urandom_range(0, 31));
        end
        case ($urandom_range(0, 9))
            0:       val = 32'sh8000_0000;
            1:       val = 32'sh7fff_ffff;
            2:       val = -32'sd1;
            3:       val = 32'sd0;
            default: val = $urandom();
        endcase
        mode = 1'($urandom_range(0, 1));
    endtask

    function automatic stim_row_t make_row(input oaid_pkg::op_t op, input int pos,
                                           input logic [31:0] val, input int mode,
                                           input int typed, input oaid_pkg::status_t st,
                                           input int cnt);
        stim_row_t row;
        row.op          = op;
        row.pos         = POS_W'(pos);
        row.value       = val;
        row.mode        = mode[0];
        row.typed       = typed[0];
        row.want_status = st;
        row.want_count  = COUNT_W'(cnt);
        return row;
    endfunction

    // result side: pop at random and compare against the oldest expectation
    always @(posedge clk)
    begin
        oaid_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing outstanding",
                                32'({count, status, last}), '0);
            else
            begin
                want = awaited_results.pop_front();
                if (data !== want.data)
                    report_mismatch("data", data, want.data);
                if (count !== want.count)
                    report_mismatch("count", 32'(count), 32'(want.count));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
        pop <= ($urandom_range(0, 99) >= drain_idle_pct);
    end

    initial
    begin
        oaid_pkg::op_t            op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     mode;

        for (int i = 0; i < CAPACITY; i++)
            mirror_entries[i] = '0;
        mirror_fill = 0;

        directed_table.push_back(make_row(oaid_pkg::OP_SIZE,    0,  32'h0,        0, 1,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 0,  32'h0,        0, 1,
                                          oaid_pkg::ST_EMPTY,   0));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  1,  32'h0,        1, 1,
                                          oaid_pkg::ST_INVALID, 0));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  0,  32'h0,        0, 1,
                                          oaid_pkg::ST_INVALID, 0));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  1,  32'h5,        0, 1,
                                          oaid_pkg::ST_INVALID, 0));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  31, 32'h1,        1, 1,
                                          oaid_pkg::ST_INVALID, 0));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  0,  32'h7fffffff, 0, 1,
                                          oaid_pkg::ST_OK,      1));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  0,  32'h80000000, 0, 1,
                                          oaid_pkg::ST_OK,      2));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  2,  32'hffffffff, 1, 1,
                                          oaid_pkg::ST_OK,      3));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  1,  32'h0,        0, 1,
                                          oaid_pkg::ST_OK,      4));
        directed_table.push_back(make_row(oaid_pkg::OP_INSERT,  2,  32'ha5a5a5a5, 1, 1,
                                          oaid_pkg::ST_OK,      5));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 0,  32'h0,        0, 0,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  0,  32'h0,        1, 1,
                                          oaid_pkg::ST_INVALID, 5));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  6,  32'h0,        0, 1,
                                          oaid_pkg::ST_INVALID, 5));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  31, 32'h0,        1, 1,
                                          oaid_pkg::ST_INVALID, 5));
        // hole filled from the tail, then shifted down
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  1,  32'h0,        0, 0,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 0,  32'h0,        0, 0,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  2,  32'h0,        1, 0,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 0,  32'h0,        0, 0,
                                          oaid_pkg::ST_OK,      0));
        // removing the last slot ignores the mode
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  3,  32'h0,        0, 1,
                                          oaid_pkg::ST_OK,      2));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  2,  32'h0,        1, 1,
                                          oaid_pkg::ST_OK,      1));
        directed_table.push_back(make_row(oaid_pkg::OP_SIZE,    31, 32'hffffffff, 1, 1,
                                          oaid_pkg::ST_OK,      1));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 31, 32'h12345678, 1, 0,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DELETE,  1,  32'h0,        1, 1,
                                          oaid_pkg::ST_OK,      0));
        directed_table.push_back(make_row(oaid_pkg::OP_DISPLAY, 0,  32'h0,        0, 1,
                                          oaid_pkg::ST_EMPTY,   0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
        begin
            drive_item(directed_table[i].op, directed_table[i].pos,
                       directed_table[i].value, directed_table[i].mode);
            apply_array_op(directed_table[i].op, directed_table[i].pos,
                           directed_table[i].value, directed_table[i].mode);
            if (directed_table[i].typed)
                awaited_results.push_back('{data: '0, count: directed_table[i].want_count,
                                            status: directed_table[i].want_status, last: 1'b1});
            else
                for (int k = 0; k < op_result_n; k++)
                    awaited_results.push_back(op_results[k]);
            feed_gap();
        end
        wait_all_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            feed_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 75 : 0;
            drain_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 22 : 0;
            @(posedge clk);
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                pick_random_item(op, pos, val, mode);
                drive_item(op, pos, val, mode);
                apply_array_op(op, pos, val, mode);
                for (int k = 0; k < op_result_n; k++)
                    awaited_results.push_back(op_results[k]);
                feed_gap();
            end
            // hold off the sender until every outstanding result is out
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
design/oaid_pkg.sv
design/oaid_fifo.sv
design/oaid_front.sv
design/oaid_back.sv
design/ordered_array_insert_delete_core.sv
sim/ordered_array_insert_delete_core_tb.sv
